// File: hw/rtl/qesm_pkg.sv
`timescale 1ns / 1ps

package qesm_pkg;

  localparam int CountW   = 32;
  localparam int ElapsedW = 24;
  localparam int RateW    = 20;
  localparam int LimitW   = 20;
  localparam int RemW     = RateW + 1;
  localparam int CfgDataW = 24;
  localparam int CfgAddrW = 2;
  localparam int CntW     = $clog2(RateW);
  localparam int InTdataW  = 8;
  localparam int OutTdataW = 64;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_SLOW_LIMIT   = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] REG_MEDIUM_LIMIT = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] REG_TIMEOUT      = CfgAddrW'(2);
  localparam logic [CfgAddrW-1:0] REG_TICKS_PER_S  = CfgAddrW'(3);

  localparam logic [LimitW-1:0]   SLOW_LIMIT_RST   = LimitW'(10);
  localparam logic [LimitW-1:0]   MEDIUM_LIMIT_RST = LimitW'(50);
  localparam logic [ElapsedW-1:0] TIMEOUT_RST      = ElapsedW'(200000);
  localparam logic [RateW-1:0]    TICKS_PER_S_RST  = RateW'(1000000);

  // rotation codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // speed class codes
  localparam logic [1:0] SPD_STOP   = 2'd0;
  localparam logic [1:0] SPD_SLOW   = 2'd1;
  localparam logic [1:0] SPD_MEDIUM = 2'd2;
  localparam logic [1:0] SPD_FAST   = 2'd3;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_t;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic div_step;
    logic commit;
  } qesm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } qesm_status_t;

  // 4x decode, index is {old b, old a, new b, new a}
  function automatic step_t quad_step(input logic [1:0] old_pins, input logic [1:0] new_pins);
    step_t s;
    case ({old_pins, new_pins})
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
      4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DOWN;
      default:                  s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/qesm_ctrl.sv
`timescale 1ns / 1ps

module qesm_ctrl
  import qesm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  qesm_status_t status,
  output qesm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic [CntW-1:0] DivLast = CntW'(RateW - 1);

  state_t          state_r;
  logic [CntW-1:0] cnt_r;
  logic            ready_r;

  assign in_tready = ready_r;

  always_comb begin
    cmd.load_item = (state_r == S_IDLE) && in_tvalid && ready_r;
    cmd.div_start = (state_r == S_CHECK) && status.need_div;
    cmd.div_step  = (state_r == S_DIV);
    cmd.commit    = (state_r == S_FIN) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && ready_r) begin
            state_r <= S_CHECK;
            ready_r <= 1'b0;
          end
        end
        S_CHECK: begin
          cnt_r <= '0;
          if (status.need_div) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DivLast) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (status.out_free) begin
            state_r <= S_IDLE;
            ready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/qesm_dp.sv
`timescale 1ns / 1ps

module qesm_dp
  import qesm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  qesm_cmd_t           cmd,
  output qesm_status_t        status,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                pin_a,
  input  logic                pin_b,
  input  logic                button_level,
  input  logic                clear_count,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [CountW-1:0]   position,
  output logic [1:0]          rotation,
  output logic [1:0]          speed_level,
  output logic [RateW-1:0]    rate,
  output logic                button_pressed
);

  // configuration
  logic [LimitW-1:0]   slow_limit_r;
  logic [LimitW-1:0]   medium_limit_r;
  logic [ElapsedW-1:0] timeout_r;
  logic [RateW-1:0]    tps_r;

  // latched item
  logic [1:0] pins_r;
  logic       button_r;
  logic       clear_r;

  // encoder state
  logic [1:0]          last_pins_r;
  logic                primed_r;
  logic [CountW-1:0]   pos_r;
  logic [1:0]          dir_r;
  logic [1:0]          class_r;
  logic [RateW-1:0]    rate_r;
  logic [ElapsedW-1:0] ticks_r;
  logic                seen_r;

  // divider
  logic [RemW-1:0]  rem_r;
  logic [RateW-1:0] quo_r;

  // output register
  logic              out_valid_r;
  logic [CountW-1:0] out_pos_r;
  logic [1:0]        out_rot_r;
  logic [1:0]        out_spd_r;
  logic [RateW-1:0]  out_rate_r;
  logic              out_btn_r;

  step_t               step;
  logic                pulse;
  logic [ElapsedW-1:0] ticks_inc;
  logic [CountW-1:0]   pos_base;
  logic [CountW-1:0]   pos_nxt;
  logic [RateW-1:0]    rate_pulse;
  logic [1:0]          class_pulse;
  logic [ElapsedW-1:0] ticks_nxt;
  logic                seen_nxt;
  logic                stopped;
  logic [1:0]          dir_nxt;
  logic [1:0]          class_nxt;
  logic [RateW-1:0]    rate_nxt;
  logic [RemW-1:0]     trial;
  logic [ElapsedW-1:0] trial_ext;
  logic [ElapsedW-1:0] diff;
  logic                fits;

  // saturating tick count; never zero once incremented, so it is a safe divisor
  assign ticks_inc = (ticks_r == {ElapsedW{1'b1}}) ? ticks_r : ticks_r + 1'b1;
  assign step      = primed_r ? quad_step(last_pins_r, pins_r) : STEP_NONE;
  assign pulse     = (step != STEP_NONE);

  assign status.need_div = pulse && seen_r;
  assign status.out_free = !out_valid_r || out_tready;

  assign pos_base = clear_r ? '0 : pos_r;

  always_comb begin
    case (step)
      STEP_UP:   pos_nxt = pos_base + 1'b1;
      STEP_DOWN: pos_nxt = pos_base - 1'b1;
      default:   pos_nxt = pos_base;
    endcase
  end

  // first pulse keeps the held rate
  assign rate_pulse = seen_r ? quo_r : rate_r;

  always_comb begin
    if (rate_pulse < slow_limit_r) begin
      class_pulse = SPD_SLOW;
    end else if (rate_pulse < medium_limit_r) begin
      class_pulse = SPD_MEDIUM;
    end else begin
      class_pulse = SPD_FAST;
    end
  end

  assign ticks_nxt = pulse ? '0 : ticks_inc;
  assign seen_nxt  = seen_r || pulse;
  assign stopped   = !seen_nxt || (ticks_nxt > timeout_r);

  always_comb begin
    if (stopped) begin
      dir_nxt   = DIR_NONE;
      class_nxt = SPD_STOP;
      rate_nxt  = '0;
    end else if (pulse) begin
      dir_nxt   = (step == STEP_UP) ? DIR_CW : DIR_CCW;
      class_nxt = class_pulse;
      rate_nxt  = rate_pulse;
    end else begin
      dir_nxt   = dir_r;
      class_nxt = class_r;
      rate_nxt  = rate_r;
    end
  end

  // restoring divider, one quotient bit per cycle, msb first
  assign trial     = {rem_r[RemW-2:0], quo_r[RateW-1]};
  assign trial_ext = ElapsedW'(trial);
  assign fits      = (trial_ext >= ticks_inc);
  assign diff      = trial_ext - ticks_inc;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= tps_r;
    end else if (cmd.div_step) begin
      rem_r <= fits ? diff[RemW-1:0] : trial;
      quo_r <= {quo_r[RateW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pins_r   <= {pin_b, pin_a};
      button_r <= button_level;
      clear_r  <= clear_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_limit_r   <= SLOW_LIMIT_RST;
      medium_limit_r <= MEDIUM_LIMIT_RST;
      timeout_r      <= TIMEOUT_RST;
      tps_r          <= TICKS_PER_S_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SLOW_LIMIT:   slow_limit_r   <= cfg_wdata[LimitW-1:0];
        REG_MEDIUM_LIMIT: medium_limit_r <= cfg_wdata[LimitW-1:0];
        REG_TIMEOUT:      timeout_r      <= cfg_wdata[ElapsedW-1:0];
        REG_TICKS_PER_S:  tps_r          <= cfg_wdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r <= '0;
      primed_r    <= 1'b0;
      pos_r       <= '0;
      dir_r       <= DIR_NONE;
      class_r     <= SPD_STOP;
      rate_r      <= '0;
      ticks_r     <= '0;
      seen_r      <= 1'b0;
    end else if (cmd.commit) begin
      last_pins_r <= pins_r;
      primed_r    <= 1'b1;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
      class_r     <= class_nxt;
      rate_r      <= rate_nxt;
      ticks_r     <= ticks_nxt;
      seen_r      <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pos_r  <= pos_nxt;
      out_rot_r  <= dir_nxt;
      out_spd_r  <= class_nxt;
      out_rate_r <= rate_nxt;
      out_btn_r  <= !button_r;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign position       = out_pos_r;
  assign rotation       = out_rot_r;
  assign speed_level    = out_spd_r;
  assign rate           = out_rate_r;
  assign button_pressed = out_btn_r;

endmodule

// File: hw/rtl/quadrature_encoder_speed_monitor.sv
`timescale 1ns / 1ps

// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   in_tdata: pin_a, pin_b, button_level, clear_count
// out_      out  out_tvalid/out_tready out_tdata: position, rotation, speed_level, rate,
//                                      button_pressed
// cfg_      in   cfg_we                cfg_addr, cfg_wdata
//
// a tick without a pulse, or the first pulse, goes from S_IDLE through S_CHECK to S_FIN, where its
// result is loaded into the output register; a later pulse also passes through S_DIV, where
// the 20-bit rate division runs one quotient bit per cycle through one subtractor
// one tick is in flight at a time; the next is taken in the cycle after its result is
// loaded into the output register, which holds it while out_tready is low
// rst_n is synchronous; configuration registers return to their defaults

module quadrature_encoder_speed_monitor
  import qesm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InTdataW-1:0]  in_tdata,   // [0] pin_a, [1] pin_b, [2] button_level,
                                           // [3] clear_count
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutTdataW-1:0] out_tdata,  // [31:0] position, [33:32] rotation,
                                           // [35:34] speed_level, [55:36] rate,
                                           // [56] button_pressed
  input  logic                 cfg_we,
  input  logic [CfgAddrW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  qesm_cmd_t         cmd;
  qesm_status_t      status;
  logic [CountW-1:0] position;
  logic [1:0]        rotation;
  logic [1:0]        speed_level;
  logic [RateW-1:0]  rate;
  logic              button_pressed;

  qesm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  qesm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .pin_a          (in_tdata[0]),
    .pin_b          (in_tdata[1]),
    .button_level   (in_tdata[2]),
    .clear_count    (in_tdata[3]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .position       (position),
    .rotation       (rotation),
    .speed_level    (speed_level),
    .rate           (rate),
    .button_pressed (button_pressed)
  );

  assign out_tdata = {
    {(OutTdataW - CountW - 4 - RateW - 1){1'b0}},
    button_pressed, rate, speed_level, rotation, position
  };

`ifndef NO_ASSERTIONS
  // a result is only loaded when the output register can take it
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.out_free)
    else $error("result loaded over an untaken result");

  // a new tick is never taken in the cycle a result is loaded
  a_accept_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !cmd.commit)
    else $error("transfer in while committing");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented");

  // direction and class are set and cleared together
  a_dir_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((rotation == DIR_NONE) == (speed_level == SPD_STOP)))
    else $error("rotation and speed class disagree on stopped");
`endif

endmodule
